// ===== hdl/co2eng_pkg.sv =====
package co2eng_pkg;

    localparam int FRAME_BYTES = 9;
    localparam int QUEUE_DEPTH = 4;

    // action selector codes
    localparam logic [2:0] ACT_READ  = 3'd0;
    localparam logic [2:0] ACT_RANGE = 3'd1;
    localparam logic [2:0] ACT_ABC   = 3'd2;
    localparam logic [2:0] ACT_ZERO  = 3'd3;
    localparam logic [2:0] ACT_RX    = 3'd4;
    localparam logic [2:0] ACT_TICK  = 3'd5;

    // result kinds
    localparam logic [1:0] KIND_TX      = 2'd0;
    localparam logic [1:0] KIND_VALUE   = 2'd1;
    localparam logic [1:0] KIND_TIMEOUT = 2'd2;
    localparam logic [1:0] KIND_CKSUM   = 2'd3;

    // configuration register indexes
    localparam logic [3:0] REG_RANGE = 4'd0;
    localparam logic [3:0] REG_ABC   = 4'd1;

    // frame constants
    localparam logic [7:0] FRM_START  = 8'hFF;
    localparam logic [7:0] FRM_ADDR   = 8'h01;
    localparam logic [7:0] OP_READ    = 8'h86;
    localparam logic [7:0] OP_RANGE   = 8'h99;
    localparam logic [7:0] OP_ABC     = 8'h79;
    localparam logic [7:0] OP_ZERO    = 8'h87;
    localparam logic [7:0] ABC_ON     = 8'hA0;
    localparam logic [15:0] RANGE_HI_PPM = 16'd5000;
    localparam logic [15:0] RANGE_LO_PPM = 16'd2000;

    // reply buffer preset and byte positions
    localparam logic [7:0] RX_PRESET = 8'h01;
    localparam int POS_START  = 0;
    localparam int POS_ADDR   = 1;
    localparam int POS_OP     = 2;
    localparam int POS_ARG0   = 3;
    localparam int POS_ARG1   = 4;
    localparam int POS_CHK    = FRAME_BYTES - 1;
    localparam int POS_PPM_HI = 2;
    localparam int POS_PPM_LO = 3;
    // sum of bytes 1..7 right after preset
    localparam logic [7:0] SUM_INIT = 8'(POS_CHK - POS_ADDR);

    localparam int CNT_W = $clog2(FRAME_BYTES + 1);
    localparam int IDX_W = $clog2(FRAME_BYTES);

    // one unit of work for the back end: a whole frame or one report
    typedef struct packed {
        logic        frame;
        logic [1:0]  kind;
        logic [7:0]  op;
        logic [7:0]  arg0;
        logic [7:0]  arg1;
        logic [7:0]  chk;
        logic [15:0] ppm;
    } job_t;

endpackage

// ===== hdl/co2eng_front.sv =====
module co2eng_front
    import co2eng_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [2:0]  action,
    input  logic [7:0]  rx_byte,
    input  logic [15:0] timeout_ticks,
    input  logic        cfg_valid,
    input  logic [3:0]  cfg_index,
    input  logic [7:0]  cfg_data,
    output logic        push,
    output job_t        push_job
);

    logic             range_sel_reg, range_sel_next;
    logic             abc_en_reg, abc_en_next;
    logic             awaiting_reg, awaiting_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [15:0]      ticks_reg, ticks_next;
    logic [7:0]       sum_reg, sum_next;
    logic [7:0]       ppm_hi_reg, ppm_hi_next;
    logic [7:0]       ppm_lo_reg, ppm_lo_next;
    logic [15:0]      range_word;

    function automatic job_t make_frame(logic [7:0] op, logic [7:0] a0, logic [7:0] a1);
        job_t j;
        j       = '0;
        j.frame = 1'b1;
        j.kind  = KIND_TX;
        j.op    = op;
        j.arg0  = a0;
        j.arg1  = a1;
        j.chk   = 8'(8'd0 - (FRM_ADDR + op + a0 + a1));
        return j;
    endfunction

    function automatic job_t make_report(logic empty_reply, logic [7:0] hi, logic [7:0] lo,
                                         logic [7:0] last_byte, logic [7:0] sum);
        job_t j;
        j = '0;
        if (empty_reply)
        begin
            j.kind = KIND_TIMEOUT;
        end
        else if (last_byte != 8'(8'd0 - sum))
        begin
            j.kind = KIND_CKSUM;
        end
        else
        begin
            j.kind = KIND_VALUE;
            j.ppm  = {hi, lo};
        end
        return j;
    endfunction

    assign range_word = range_sel_reg ? RANGE_HI_PPM : RANGE_LO_PPM;

    always_comb
    begin
        range_sel_next = range_sel_reg;
        abc_en_next    = abc_en_reg;
        awaiting_next  = awaiting_reg;
        count_next     = count_reg;
        ticks_next     = ticks_reg;
        sum_next       = sum_reg;
        ppm_hi_next    = ppm_hi_reg;
        ppm_lo_next    = ppm_lo_reg;
        push           = 1'b0;
        push_job       = '0;

        if (cfg_valid)
        begin
            if (cfg_index == REG_RANGE)
                range_sel_next = cfg_data[0];
            else if (cfg_index == REG_ABC)
                abc_en_next = cfg_data[0];
        end

        if (in_valid && in_ready)
        begin
            unique case (action)
                ACT_READ:
                begin
                    awaiting_next = 1'b1;
                    count_next    = '0;
                    ticks_next    = timeout_ticks;
                    sum_next      = SUM_INIT;
                    ppm_hi_next   = RX_PRESET;
                    ppm_lo_next   = RX_PRESET;
                    push          = 1'b1;
                    push_job      = make_frame(OP_READ, 8'h00, 8'h00);
                end
                ACT_RANGE:
                begin
                    push     = 1'b1;
                    push_job = make_frame(OP_RANGE, range_word[15:8], range_word[7:0]);
                end
                ACT_ABC:
                begin
                    push     = 1'b1;
                    push_job = make_frame(OP_ABC, abc_en_reg ? ABC_ON : 8'h00, 8'h00);
                end
                ACT_ZERO:
                begin
                    push     = 1'b1;
                    push_job = make_frame(OP_ZERO, 8'h00, 8'h00);
                end
                ACT_RX:
                begin
                    if (awaiting_reg && count_reg < CNT_W'(FRAME_BYTES))
                    begin
                        count_next = count_reg + CNT_W'(1);
                        if (count_reg == CNT_W'(POS_PPM_HI))
                            ppm_hi_next = rx_byte;
                        if (count_reg == CNT_W'(POS_PPM_LO))
                            ppm_lo_next = rx_byte;
                        // running sum over bytes 1..7, replacing the preset
                        if (count_reg != CNT_W'(POS_START) && count_reg != CNT_W'(POS_CHK))
                            sum_next = sum_reg + rx_byte - RX_PRESET;
                        if (count_reg == CNT_W'(POS_CHK))
                        begin
                            awaiting_next = 1'b0;
                            push          = 1'b1;
                            push_job      = make_report(1'b0, ppm_hi_reg, ppm_lo_reg,
                                                        rx_byte, sum_reg);
                        end
                    end
                end
                ACT_TICK:
                begin
                    if (awaiting_reg)
                    begin
                        if (ticks_reg <= 16'd1)
                        begin
                            ticks_next    = '0;
                            awaiting_next = 1'b0;
                            push          = 1'b1;
                            push_job      = make_report(count_reg == '0, ppm_hi_reg,
                                                        ppm_lo_reg, RX_PRESET, sum_reg);
                        end
                        else
                        begin
                            ticks_next = ticks_reg - 16'd1;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            range_sel_reg <= 1'b0;
            abc_en_reg    <= 1'b0;
            awaiting_reg  <= 1'b0;
            count_reg     <= '0;
            ticks_reg     <= '0;
            sum_reg       <= SUM_INIT;
            ppm_hi_reg    <= RX_PRESET;
            ppm_lo_reg    <= RX_PRESET;
        end
        else
        begin
            range_sel_reg <= range_sel_next;
            abc_en_reg    <= abc_en_next;
            awaiting_reg  <= awaiting_next;
            count_reg     <= count_next;
            ticks_reg     <= ticks_next;
            sum_reg       <= sum_next;
            ppm_hi_reg    <= ppm_hi_next;
            ppm_lo_reg    <= ppm_lo_next;
        end
    end

endmodule

// ===== hdl/co2eng_fifo.sv =====
module co2eng_fifo
    import co2eng_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    output logic full,
    input  logic pop,
    output job_t head,
    output logic empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    job_t             mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        if (do_push && !do_pop)
            count_next = count_reg + CNT_W'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== hdl/co2eng_back.sv =====
module co2eng_back
    import co2eng_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  job_t        head,
    input  logic        empty,
    output logic        pop,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  kind,
    output logic [7:0]  tx_byte,
    output logic [15:0] concentration,
    output logic        last
);

    logic             valid_reg, valid_next;
    logic [1:0]       kind_reg, kind_next;
    logic [7:0]       tx_reg, tx_next;
    logic [15:0]      ppm_reg, ppm_next;
    logic             last_reg, last_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             advance;
    logic             job_done;
    logic [7:0]       frame_byte;

    assign advance  = !valid_reg || out_ready;
    assign job_done = !head.frame || (idx_reg == IDX_W'(POS_CHK));
    assign pop      = advance && !empty && job_done;

    always_comb
    begin
        case (idx_reg)
            IDX_W'(POS_START): frame_byte = FRM_START;
            IDX_W'(POS_ADDR):  frame_byte = FRM_ADDR;
            IDX_W'(POS_OP):    frame_byte = head.op;
            IDX_W'(POS_ARG0):  frame_byte = head.arg0;
            IDX_W'(POS_ARG1):  frame_byte = head.arg1;
            IDX_W'(POS_CHK):   frame_byte = head.chk;
            default:           frame_byte = 8'h00;
        endcase
    end

    always_comb
    begin
        valid_next = valid_reg;
        kind_next  = kind_reg;
        tx_next    = tx_reg;
        ppm_next   = ppm_reg;
        last_next  = last_reg;
        idx_next   = idx_reg;
        if (advance)
        begin
            valid_next = !empty;
            if (!empty)
            begin
                kind_next = head.kind;
                last_next = job_done;
                if (head.frame)
                begin
                    tx_next  = frame_byte;
                    ppm_next = '0;
                    idx_next = job_done ? '0 : idx_reg + IDX_W'(1);
                end
                else
                begin
                    tx_next  = '0;
                    ppm_next = head.ppm;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg <= kind_next;
        tx_reg   <= tx_next;
        ppm_reg  <= ppm_next;
        last_reg <= last_next;
    end

    assign out_valid     = valid_reg;
    assign kind          = kind_reg;
    assign tx_byte       = tx_reg;
    assign concentration = ppm_reg;
    assign last          = last_reg;

endmodule

// ===== hdl/co2_sensor_uart_command_engine_core.sv =====
// a result is registered in the job queue, then in the back end output register
// throughput: one input item per cycle while the job queue has room
// a command holds the back end for nine bytes (one per cycle unless stalled), a report for one
// s_tready drops only when the job queue is full; cfg writes are always taken
// reset: asynchronous, active low; clears control state and config registers, no clearing pass
module co2_sensor_uart_command_engine_core
    import co2eng_pkg::*;
#(
    parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,    // rx_byte [7:0], timeout_ticks [23:8]
    input  logic [2:0]  s_tuser,    // action [2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,    // tx_byte [7:0], concentration [23:8]
    output logic [1:0]  m_tuser,    // kind [1:0]
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [3:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    logic        push;
    job_t        push_job;
    logic        full;
    logic        pop;
    job_t        head;
    logic        empty;
    logic [7:0]  tx_byte;
    logic [15:0] concentration;

    assign s_tready  = !full;
    assign cfg_ready = 1'b1;

    co2eng_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (s_tvalid),
        .in_ready      (s_tready),
        .action        (s_tuser),
        .rx_byte       (s_tdata[7:0]),
        .timeout_ticks (s_tdata[23:8]),
        .cfg_valid     (cfg_valid),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .push          (push),
        .push_job      (push_job)
    );

    co2eng_fifo #(
        .DEPTH (QUEUE_DEPTH_P)
    ) u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .full     (full),
        .pop      (pop),
        .head     (head),
        .empty    (empty)
    );

    co2eng_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head          (head),
        .empty         (empty),
        .pop           (pop),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .kind          (m_tuser),
        .tx_byte       (tx_byte),
        .concentration (concentration),
        .last          (m_tlast)
    );

    assign m_tdata = {concentration, tx_byte};

endmodule

// ===== hdl/co2eng_checker.sv =====
module co2eng_checker
    import co2eng_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [23:0] s_tdata,
    input logic [2:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic [1:0]  m_tuser,
    input logic        m_tlast,
    input logic        cfg_valid,
    input logic        cfg_ready,
    input logic [3:0]  cfg_index,
    input logic [7:0]  cfg_data
);

    // a stalled result holds its value
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                  && $stable(m_tlast))
        else $error("stalled result changed");

    // reports are single results
    a_report_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser != KIND_TX |-> m_tlast)
        else $error("report without last");

    // concentration only on a valid reading
    a_ppm_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser != KIND_VALUE |-> m_tdata[23:8] == 16'd0)
        else $error("concentration set on non reading");

    // after a frame ends the next frame byte is the start byte
    a_frame_start: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && m_tuser == KIND_TX && m_tlast
        ##1 m_tvalid && m_tuser == KIND_TX |-> m_tdata[7:0] == FRM_START)
        else $error("frame does not open with start byte");

endmodule

bind co2_sensor_uart_command_engine_core co2eng_checker u_co2eng_checker (.*);
